// File: src/cst_pkg.sv
`default_nettype none
package cst_pkg;

   localparam logic [1:0] OP_OPEN  = 2'd0;
   localparam logic [1:0] OP_CLOSE = 2'd1;
   localparam logic [1:0] OP_DATA  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_SHORT   = 2'd3;

   localparam logic [1:0] ECHO_NONE = 2'd0;

   localparam logic [15:0] COOKIE_LAST = 16'd65534;

   typedef struct packed {
      logic [15:0] cookie;
      logic        mode;
      logic [31:0] last_time;
      logic [63:0] max_sequence;
      logic [31:0] received;
      logic [31:0] misordered;
      logic [31:0] unexpected;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic expired;
   } match_type;

   function automatic logic [15:0] cookie_next(input logic [15:0] c);
      logic [15:0] r;
      r = (c == COOKIE_LAST) ? 16'd0 : c + 16'd1;
      return r;
   endfunction

endpackage
`default_nettype wire

// File: src/client_session_table.sv
// Each table pass reads one entry per cycle. Close and tick take one pass, a packet one
// pass followed by the read and update states, an open one pass per cookie candidate
// (more when generated cookies collide with open sessions).
// One item at a time: the request side is ready only when the sequencer is idle, so a new
// item is taken only after the previous response has been accepted.
// Synchronous reset clears all valid bits, the cookie counter and sets the timeout to 60.
`default_nettype none
module client_session_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_cookie,
   input  wire logic        req_echo_mode,
   input  wire logic [63:0] req_sequence_req,
   input  wire logic        req_packet_short,
   input  wire logic [31:0] req_now_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_result_cookie,
   output logic [1:0]       rsp_echo_action,
   output logic [6:0]       rsp_removed_count,
   output logic [31:0]      rsp_out_of_order_count,
   output logic [31:0]      rsp_received_count,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_UPDATE, S_RESP} state_type;

   state_type state_ff, state_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [15:0] counter_ff, counter_in, cand_ff, cand_in, timeout_ff, timeout_in;
   logic [AW-1:0] cnt_ff, cnt_in, pidx_ff, pidx_in, fidx_ff, fidx_in, free_idx_ff, free_idx_in;
   logic issue_ff, issue_in, pend_ff, pend_in, found_ff, found_in, free_ff, free_in;
   logic [6:0] removed_ff, removed_in;
   logic [1:0] op_ff, op_in;
   logic [15:0] key_ff, key_in;
   logic mode_ff, mode_in, short_ff, short_in;
   logic [63:0] seq_ff, seq_in;
   logic [31:0] now_ff, now_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in, echo_ff, echo_in;
   logic [15:0] rcookie_ff, rcookie_in;
   logic [6:0] rremoved_ff, rremoved_in;
   logic [31:0] ooo_ff, ooo_in, rcv_ff, rcv_in;

   logic [AW-1:0] rd_addr;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   cst_pkg::entry_type wr_data, rd_data;
   cst_pkg::match_type m;
   logic vbit, hit_c, free_c, last_c;
   logic [AW-1:0] fidx_c, free_idx_c;
   logic [6:0] removed_c;
   logic [15:0] match_key;

   cst_entry_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign vbit = valid_ff[pidx_ff];
   assign match_key = (op_ff == cst_pkg::OP_OPEN) ? cand_ff : key_ff;

   cst_entry_match u_match (
      .entry_valid(vbit), .entry(rd_data), .key(match_key),
      .now_seconds(now_ff), .timeout(timeout_ff), .result(m)
   );

   assign hit_c      = found_ff || (pend_ff && m.hit);
   assign fidx_c     = found_ff ? fidx_ff : pidx_ff;
   assign free_c     = free_ff || (pend_ff && !vbit);
   assign free_idx_c = free_ff ? free_idx_ff : pidx_ff;
   assign removed_c  = removed_ff + 7'(pend_ff && m.expired);
   assign last_c     = pend_ff && (pidx_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; counter_in = counter_ff; cand_in = cand_ff;
      timeout_in = csr_write_enable ? csr_write_data : timeout_ff;
      cnt_in = cnt_ff; pidx_in = cnt_ff; fidx_in = fidx_ff; free_idx_in = free_idx_ff;
      issue_in = issue_ff; pend_in = 1'b0; found_in = found_ff; free_in = free_ff;
      removed_in = removed_ff;
      op_in = op_ff; key_in = key_ff; mode_in = mode_ff; short_in = short_ff;
      seq_in = seq_ff; now_in = now_ff;
      rsp_valid_in = rsp_valid_ff; status_in = status_ff; echo_in = echo_ff;
      rcookie_in = rcookie_ff; rremoved_in = rremoved_ff; ooo_in = ooo_ff; rcv_in = rcv_ff;
      rd_addr = cnt_ff; wr_en = 1'b0; wr_addr = free_idx_c; wr_data = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation; key_in = req_cookie; mode_in = req_echo_mode;
               seq_in = req_sequence_req; short_in = req_packet_short;
               now_in = req_now_seconds;
               cand_in = cst_pkg::cookie_next(counter_ff);
               cnt_in = '0; issue_in = 1'b1; found_in = 1'b0; free_in = 1'b0;
               removed_in = '0;
               status_in = cst_pkg::ST_OK; rcookie_in = req_cookie;
               echo_in = cst_pkg::ECHO_NONE; rremoved_in = '0; ooo_in = '0; rcv_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            pend_in = issue_ff;
            if (issue_ff) begin
               cnt_in = cnt_ff + AW'(1);
               if (cnt_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end
            end
            found_in = hit_c; fidx_in = fidx_c; free_in = free_c; free_idx_in = free_idx_c;
            removed_in = removed_c;
            if (op_ff == cst_pkg::OP_TICK && pend_ff && m.expired) begin
               valid_in[pidx_ff] = 1'b0;
            end
            if (last_c) begin
               state_in = S_RESP; rsp_valid_in = 1'b1;
               unique case (op_ff)
                  cst_pkg::OP_OPEN: begin
                     if (!free_c) begin
                        status_in = cst_pkg::ST_FULL; rcookie_in = '0;
                     end else if (hit_c) begin
                        // Candidate cookie is in use: try the next one with a fresh pass.
                        cand_in = cst_pkg::cookie_next(cand_ff);
                        cnt_in = '0; issue_in = 1'b1; found_in = 1'b0; free_in = 1'b0;
                        state_in = S_SCAN; rsp_valid_in = 1'b0;
                     end else begin
                        wr_en = 1'b1;
                        wr_data.cookie = cand_ff; wr_data.mode = mode_ff;
                        wr_data.last_time = now_ff; wr_data.max_sequence = '0;
                        wr_data.received = '0; wr_data.misordered = '0;
                        wr_data.unexpected = '0;
                        valid_in[free_idx_c] = 1'b1;
                        counter_in = cand_ff; rcookie_in = cand_ff;
                     end
                  end
                  cst_pkg::OP_CLOSE: begin
                     if (hit_c) begin
                        valid_in[fidx_c] = 1'b0;
                     end else begin
                        status_in = cst_pkg::ST_UNKNOWN;
                     end
                  end
                  cst_pkg::OP_DATA: begin
                     if (hit_c) begin
                        state_in = S_READ; rsp_valid_in = 1'b0;
                     end else begin
                        status_in = cst_pkg::ST_UNKNOWN;
                     end
                  end
                  cst_pkg::OP_TICK: begin
                     rremoved_in = removed_c;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            rd_addr = fidx_ff;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            wr_en = 1'b1; wr_addr = fidx_ff;
            wr_data.last_time = now_ff;
            if (short_ff) begin
               wr_data.unexpected = rd_data.unexpected + 32'd1;
               status_in = cst_pkg::ST_SHORT;
            end else begin
               wr_data.received = rd_data.received + 32'd1;
               if ($signed(rd_data.max_sequence) > $signed(seq_ff)) begin
                  wr_data.misordered = rd_data.misordered + 32'd1;
               end else begin
                  wr_data.max_sequence = seq_ff;
               end
               echo_in = {1'b0, rd_data.mode} + 2'd1;
            end
            ooo_in = wr_data.misordered; rcv_in = wr_data.received;
            rsp_valid_in = 1'b1; state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; counter_ff <= '0; timeout_ff <= 16'd60;
         issue_ff <= 1'b0; pend_ff <= 1'b0; found_ff <= 1'b0; free_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; counter_ff <= counter_in;
         timeout_ff <= timeout_in; issue_ff <= issue_in; pend_ff <= pend_in;
         found_ff <= found_in; free_ff <= free_in; rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff <= cand_in; cnt_ff <= cnt_in; pidx_ff <= pidx_in; fidx_ff <= fidx_in;
      free_idx_ff <= free_idx_in; removed_ff <= removed_in;
      op_ff <= op_in; key_ff <= key_in; mode_ff <= mode_in; short_ff <= short_in;
      seq_ff <= seq_in; now_ff <= now_in;
      status_ff <= status_in; echo_ff <= echo_in; rcookie_ff <= rcookie_in;
      rremoved_ff <= rremoved_in; ooo_ff <= ooo_in; rcv_ff <= rcv_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_result_cookie = rcookie_ff;
   assign rsp_echo_action = echo_ff;
   assign rsp_removed_count = rremoved_ff;
   assign rsp_out_of_order_count = ooo_ff;
   assign rsp_received_count = rcv_ff;

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request accepted while a beat is pending");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("sequencer did not start");
   a_full_cookie: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cst_pkg::ST_FULL) |-> (rsp_result_cookie == 16'd0))
      else $error("full open returned a cookie");
   a_echo_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_echo_action != cst_pkg::ECHO_NONE) |-> (rsp_status == cst_pkg::ST_OK))
      else $error("echo on a failed beat");
endmodule
`default_nettype wire

// File: src/cst_entry_ram.sv
`default_nettype none
module cst_entry_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire cst_pkg::entry_type  wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output cst_pkg::entry_type       rd_data
);
   cst_pkg::entry_type mem [DEPTH];
   cst_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: src/cst_entry_match.sv
`default_nettype none
module cst_entry_match (
   input  wire logic               entry_valid,
   input  wire cst_pkg::entry_type entry,
   input  wire logic [15:0]        key,
   input  wire logic [31:0]        now_seconds,
   input  wire logic [15:0]        timeout,
   output cst_pkg::match_type      result
);
   logic [32:0] idle;

   // Idle time is a signed 33-bit difference, so a stored time ahead of now never ages.
   assign idle = {1'b0, now_seconds} - {1'b0, entry.last_time};

   assign result.hit     = entry_valid && (entry.cookie == key);
   assign result.expired = entry_valid && ($signed(idle) > $signed({17'd0, timeout}));
endmodule
`default_nettype wire
